// ===== design/ascii_record_to_card_image_macros.svh =====
// ----------------------------------------------------------------------------
// ascii_record_to_card_image assertion macros
// Shared concurrent assertion forms for the card image builder.
// ----------------------------------------------------------------------------
`ifndef ASCII_RECORD_TO_CARD_IMAGE_MACROS_SVH
`define ASCII_RECORD_TO_CARD_IMAGE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ARCI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ARCI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/arci_pkg.sv =====
// ----------------------------------------------------------------------------
// arci_pkg
// Constants, codes and types of the ASCII record to card image builder.
// ----------------------------------------------------------------------------
`default_nettype none

package arci_pkg;

  localparam int CARD_COLUMNS = 80;
  localparam int TAB_STOP     = 8;

  // column counter holds 0 .. CARD_COLUMNS, store index 0 .. CARD_COLUMNS-1
  localparam int COL_W  = $clog2(CARD_COLUMNS + 1);
  localparam int MEM_AW = $clog2(CARD_COLUMNS);

  localparam logic [7:0] CH_EOF = 8'h1A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam logic [7:0] FILL_RESET = 8'h40;

  localparam int APB_AW = 4;

  typedef enum logic [1:0] {
    REG_TRUNCATE_LONG = 2'd0,
    REG_EOF_EXCEPTION = 2'd1,
    REG_FILL_BYTE     = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED         = 3'd0,
    ST_COMPLETE         = 3'd1,
    ST_DATA_CHECK       = 3'd2,
    ST_EOF_EXCEPTION    = 3'd3,
    ST_EOF_INTERVENTION = 3'd4
  } status_t;

endpackage

`default_nettype wire

// ===== design/ascii_record_to_card_image.sv =====
// Pipeline: an accepted transaction passes stage 1, then the output register, to m_tvalid.
// Throughput: one transaction per cycle unless m_tready stalls; set by the single
//   write port and the registered read port of the card store, both used once per item.
// Reset: synchronous, active high; clears the card state, the written mask,
//   the pipeline valids and the registers (fill byte back to 0x40).
// The card store itself is not cleared: the written mask gates every read.
// ----------------------------------------------------------------------------
// ascii_record_to_card_image
// Builds an 80-column card image from a stream of ASCII bytes and serves
// column reads from the card store.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ascii_record_to_card_image_macros.svh"

module ascii_record_to_card_image
  import arci_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // input stream
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [23:0]       s_tdata,  // raw_char[7:0], coded_char[15:8], column[22:16]
  input  wire logic [1:0]        s_tuser,  // cmd[0], end_of_stream[1]
  // result stream
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [15:0]            m_tdata,  // status[2:0], card_byte[10:3]
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // registers
  logic       truncate_long;
  logic       eof_reports_exception;
  logic [7:0] fill_byte;

  // card state
  logic [COL_W-1:0]        next_column;
  logic                    card_open;
  logic [CARD_COLUMNS-1:0] written_mask;
  logic [7:0]              card_mem [CARD_COLUMNS];
  logic [7:0]              mem_q;

  // input fields
  logic [7:0] raw_char;
  logic [7:0] coded_char;
  logic [6:0] column;
  logic       cmd;
  logic       end_of_stream;

  // stage 1
  logic       s1_valid;
  logic       s1_read;
  logic       s1_hit;
  logic [7:0] s1_fill;
  status_t    s1_status;
  logic       s1_adv;
  logic [7:0] s1_byte;

  logic s_accept;
  logic m_accept;

  // feed datapath
  logic [COL_W-1:0]        col0;
  logic [COL_W-1:0]        next_column_next;
  logic                    card_open_next;
  logic [CARD_COLUMNS-1:0] mask0;
  logic [CARD_COLUMNS-1:0] written_mask_next;
  logic [COL_W:0]          tab_col;
  status_t                 feed_status;
  logic                    mem_we;
  logic [MEM_AW-1:0]       wr_addr;
  logic [MEM_AW-1:0]       rd_addr;
  logic                    rd_in_range;
  logic                    rd_hit;

  assign raw_char      = s_tdata[7:0];
  assign coded_char    = s_tdata[15:8];
  assign column        = s_tdata[22:16];
  assign cmd           = s_tuser[0];
  assign end_of_stream = s_tuser[1];

  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign s_accept = s_tvalid && s_tready;
  assign m_accept = m_tvalid && m_tready;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    case (reg_index_t'(paddr[3:2]))
      REG_TRUNCATE_LONG: prdata = {31'd0, truncate_long};
      REG_EOF_EXCEPTION: prdata = {31'd0, eof_reports_exception};
      REG_FILL_BYTE:     prdata = {24'd0, fill_byte};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      truncate_long         <= 1'b0;
      eof_reports_exception <= 1'b0;
      fill_byte             <= FILL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
      case (reg_index_t'(paddr[3:2]))
        REG_TRUNCATE_LONG: truncate_long         <= pwdata[0];
        REG_EOF_EXCEPTION: eof_reports_exception <= pwdata[0];
        REG_FILL_BYTE:     fill_byte             <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- feed
  // a feed on a closed card starts a fresh one at column zero
  assign col0  = card_open ? next_column : '0;
  assign mask0 = card_open ? written_mask : '0;

  always_comb begin
    next_column_next  = col0;
    card_open_next    = 1'b1;
    written_mask_next = mask0;
    feed_status       = ST_ACCEPTED;
    mem_we            = 1'b0;
    tab_col           = (COL_W + 1)'((int'(col0) / TAB_STOP + 1) * TAB_STOP);
    if (end_of_stream || raw_char == CH_EOF) begin
      card_open_next = 1'b0;
      if (col0 != '0) begin
        feed_status = ST_COMPLETE;
      end else if (eof_reports_exception) begin
        feed_status = ST_EOF_EXCEPTION;
      end else begin
        feed_status = ST_EOF_INTERVENTION;
      end
    end else if (raw_char == CH_CR) begin
      feed_status = ST_ACCEPTED;
    end else if (raw_char == CH_LF) begin
      card_open_next = 1'b0;
      feed_status    = ST_COMPLETE;
    end else if (raw_char == CH_TAB) begin
      // cap at the last column boundary
      if (int'(tab_col) > CARD_COLUMNS) begin
        next_column_next = COL_W'(CARD_COLUMNS);
      end else begin
        next_column_next = tab_col[COL_W-1:0];
      end
    end else if (int'(col0) >= CARD_COLUMNS) begin
      if (!truncate_long) begin
        card_open_next   = 1'b0;
        next_column_next = '0;
        feed_status      = ST_DATA_CHECK;
      end
    end else begin
      mem_we                     = 1'b1;
      written_mask_next[wr_addr] = 1'b1;
      next_column_next           = col0 + COL_W'(1);
    end
  end

  assign wr_addr = MEM_AW'(col0);

  always_ff @(posedge clk) begin
    if (rst) begin
      next_column  <= '0;
      card_open    <= 1'b0;
      written_mask <= '0;
    end else if (s_accept && !cmd) begin
      next_column  <= next_column_next;
      card_open    <= card_open_next;
      written_mask <= written_mask_next;
    end
  end

  // ---------------------------------------------------------------- store
  assign rd_in_range = int'(column) < CARD_COLUMNS;
  assign rd_addr     = rd_in_range ? MEM_AW'(column) : '0;
  assign rd_hit      = rd_in_range && written_mask[rd_addr];

  always_ff @(posedge clk) begin
    if (s_accept && !cmd && mem_we) begin
      card_mem[wr_addr] <= coded_char;
    end
    if (s_accept && cmd) begin
      mem_q <= card_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_read   <= cmd;
      s1_hit    <= rd_hit;
      s1_fill   <= fill_byte;
      s1_status <= cmd ? ST_ACCEPTED : feed_status;
    end
  end

  assign s1_byte = !s1_read ? 8'd0 : (s1_hit ? mem_q : s1_fill);

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_accept) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= {5'd0, s1_byte, s1_status};
    end
  end

  // ---------------------------------------------------------------- checks
  `ARCI_ASSERT_NOW(a_col_bound, clk, rst, 1'b1, int'(next_column) <= CARD_COLUMNS, "column counter past card end")
  `ARCI_ASSERT_NEXT(a_s1_load, clk, rst, s_accept, s1_valid, "accepted transaction lost before stage 1")
  `ARCI_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !s1_adv, s1_valid && $stable(s1_status), "stalled stage 1 dropped or changed")
  `ARCI_ASSERT_NEXT(a_dcheck, clk, rst, s_accept && !cmd && feed_status == ST_DATA_CHECK, !card_open && next_column == '0, "data check left card open")

endmodule

`default_nettype wire

// ===== verif/tb_ascii_record_to_card_image.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_record_to_card_image
// Self-checking bench for the card image builder. A short table of stimulus
// covers empty-file marks, tabs up to the last column, overflow and column
// reads. Random records, column reads and noise then run under five register
// settings. Each result is checked field by field against its table row or the
// bench's card state predictor. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb_ascii_record_to_card_image;
  import arci_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_ITEMS  = 185;
  localparam int PHASES       = 5;

  typedef struct packed {
    status_t    status;
    logic [7:0] card_byte;
  } card_result_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] raw;
    logic [7:0] coded;
    logic       eos;
    logic [6:0] col;
    logic       typed;
    status_t    status;
    logic [7:0] card_byte;
  } stim_row_t;

  // cmd, raw, coded, eos, column, typed, status, card_byte
  localparam stim_row_t DIRECTED_ROWS [29] = '{
    '{1'b1, 8'h00,  8'h00, 1'b0, 7'd0,   1'b1, ST_ACCEPTED,         8'h40},
    '{1'b1, 8'hFF,  8'hFF, 1'b1, 7'd127, 1'b1, ST_ACCEPTED,         8'h40},
    '{1'b0, 8'h00,  8'h00, 1'b1, 7'd0,   1'b1, ST_EOF_INTERVENTION, 8'h00},
    '{1'b0, CH_EOF, 8'h5A, 1'b0, 7'd0,   1'b1, ST_EOF_INTERVENTION, 8'h00},
    '{1'b0, CH_CR,  8'h0D, 1'b0, 7'd0,   1'b1, ST_ACCEPTED,         8'h00},
    '{1'b0, CH_EOF, 8'h00, 1'b0, 7'd0,   1'b1, ST_EOF_INTERVENTION, 8'h00},
    '{1'b0, 8'h41,  8'hC1, 1'b0, 7'd127, 1'b1, ST_ACCEPTED,         8'h00},
    '{1'b0, 8'hFF,  8'h00, 1'b0, 7'd0,   1'b1, ST_ACCEPTED,         8'h00},
    '{1'b0, CH_TAB, 8'h05, 1'b0, 7'd0,   1'b1, ST_ACCEPTED,         8'h00},
    '{1'b0, 8'h00,  8'hFF, 1'b0, 7'd0,   1'b1, ST_ACCEPTED,         8'h00},
    '{1'b1, 8'h00,  8'h00, 1'b0, 7'd0,   1'b1, ST_ACCEPTED,         8'hC1},
    '{1'b1, 8'h00,  8'h00, 1'b0, 7'd5,   1'b1, ST_ACCEPTED,         8'h40},
    '{1'b1, 8'h00,  8'h00, 1'b0, 7'd8,   1'b1, ST_ACCEPTED,         8'hFF},
    '{1'b0, CH_LF,  8'h25, 1'b0, 7'd0,   1'b1, ST_COMPLETE,         8'h00},
    '{1'b1, 8'h00,  8'h00, 1'b0, 7'd1,   1'b1, ST_ACCEPTED,         8'h00},
    '{1'b0, CH_TAB, 8'h05, 1'b0, 7'd0,   1'b1, ST_ACCEPTED,         8'h00},
    '{1'b0, 8'hFF,  8'hFF, 1'b1, 7'd0,   1'b1, ST_COMPLETE,         8'h00},
    '{1'b0, CH_TAB, 8'h05, 1'b0, 7'd0,   1'b1, ST_ACCEPTED,         8'h00},
    '{1'b0, CH_TAB, 8'h05, 1'b0, 7'd0,   1'b1, ST_ACCEPTED,         8'h00},
    '{1'b0, CH_TAB, 8'h05, 1'b0, 7'd0,   1'b1, ST_ACCEPTED,         8'h00},
    '{1'b0, CH_TAB, 8'h05, 1'b0, 7'd0,   1'b1, ST_ACCEPTED,         8'h00},
    '{1'b0, CH_TAB, 8'h05, 1'b0, 7'd0,   1'b1, ST_ACCEPTED,         8'h00},
    '{1'b0, CH_TAB, 8'h05, 1'b0, 7'd0,   1'b1, ST_ACCEPTED,         8'h00},
    '{1'b0, CH_TAB, 8'h05, 1'b0, 7'd0,   1'b1, ST_ACCEPTED,         8'h00},
    '{1'b0, CH_TAB, 8'h05, 1'b0, 7'd0,   1'b1, ST_ACCEPTED,         8'h00},
    '{1'b0, CH_TAB, 8'h05, 1'b0, 7'd0,   1'b1, ST_ACCEPTED,         8'h00},
    '{1'b0, CH_TAB, 8'h05, 1'b0, 7'd0,   1'b1, ST_ACCEPTED,         8'h00},
    '{1'b0, CH_TAB, 8'h05, 1'b0, 7'd0,   1'b1, ST_ACCEPTED,         8'h00},
    '{1'b0, 8'h42,  8'hC2, 1'b0, 7'd0,   1'b1, ST_DATA_CHECK,       8'h00}
  };

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata  = '0;  // raw_char[7:0], coded_char[15:8], column[22:16]
  logic [1:0]        s_tuser  = '0;  // cmd[0], end_of_stream[1]
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [15:0]       m_tdata;        // status[2:0], card_byte[10:3]
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [APB_AW-1:0] paddr    = '0;
  logic [31:0]       pwdata   = '0;
  logic [31:0]       prdata;
  logic              pready;

  // predictor copy of the registers and card state
  logic                    truncate_q = 1'b0;
  logic                    eof_exc_q  = 1'b0;
  logic [7:0]              fill_q     = FILL_RESET;
  int                      col_ptr    = 0;
  logic                    card_open  = 1'b0;
  logic [CARD_COLUMNS-1:0] col_written = '0;
  logic [7:0]              card_img [CARD_COLUMNS];

  card_result_t awaited_results [$];
  int           fed_items   = 0;
  int           errors      = 0;
  int unsigned  cycle_count = 0;
  bit           calm        = 1'b0;
  int           stall_left  = 0;

  ascii_record_to_card_image u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic card_result_t predict_card_result(logic cmd, logic [7:0] raw,
                                                       logic [7:0] coded, logic eos,
                                                       logic [6:0] col);
    card_result_t r;
    int stop;
    r.status    = ST_ACCEPTED;
    r.card_byte = 8'h00;
    if (cmd) begin
      r.card_byte = fill_q;
      if (col < CARD_COLUMNS) begin
        if (col_written[col]) r.card_byte = card_img[col];
      end
      return r;
    end
    if (!card_open) begin
      col_written = '0;
      col_ptr     = 0;
      card_open   = 1'b1;
    end
    if (eos || raw == CH_EOF) begin
      card_open = 1'b0;
      r.status  = (col_ptr > 0) ? ST_COMPLETE :
                  (eof_exc_q ? ST_EOF_EXCEPTION : ST_EOF_INTERVENTION);
    end else if (raw == CH_LF) begin
      card_open = 1'b0;
      r.status  = ST_COMPLETE;
    end else if (raw == CH_TAB) begin
      stop    = (col_ptr / TAB_STOP + 1) * TAB_STOP;
      col_ptr = (stop > CARD_COLUMNS) ? CARD_COLUMNS : stop;
    end else if (raw != CH_CR) begin
      if (col_ptr >= CARD_COLUMNS) begin
        if (!truncate_q) begin
          card_open = 1'b0;
          col_ptr   = 0;
          r.status  = ST_DATA_CHECK;
        end
      end else begin
        card_img[col_ptr]    = coded;
        col_written[col_ptr] = 1'b1;
        col_ptr++;
      end
    end
    return r;
  endfunction

  // call at a rising edge; returns at the edge that accepts the transaction
  task automatic send_item(input logic cmd, input logic [7:0] raw, input logic [7:0] coded,
                           input logic eos, input logic [6:0] col,
                           input logic typed = 1'b0, input status_t t_status = ST_ACCEPTED,
                           input logic [7:0] t_byte = 8'h00);
    int gap;
    card_result_t r;
    gap = (!calm && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, col, coded, raw};
    s_tuser  <= {eos, cmd};
    do @(posedge clk); while (!s_tready);
    r = predict_card_result(cmd, raw, coded, eos, col);
    if (typed) begin
      r.status    = t_status;
      r.card_byte = t_byte;
    end
    awaited_results.push_back(r);
    fed_items++;
  endtask

  // write a register, then read it back
  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    logic [31:0] back;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_TRUNCATE_LONG: truncate_q = value[0];
      REG_EOF_EXCEPTION: eof_exc_q  = value[0];
      REG_FILL_BYTE:     fill_q     = value[7:0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    back = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (back !== value) begin
      $error("%s: expected %0h, got %0h", idx.name(), value, back);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 20) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : check_results
    card_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: status %0d, card_byte %0h", m_tdata[2:0], m_tdata[10:3]);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (m_tdata[2:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
          errors++;
        end
        if (m_tdata[10:3] !== want.card_byte) begin
          $error("card_byte: expected %0h, got %0h", want.card_byte, m_tdata[10:3]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int         phase;
    int         target;
    int         len;
    int         pick;
    int         n;
    logic [6:0] rd_col;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].raw, DIRECTED_ROWS[i].coded,
                DIRECTED_ROWS[i].eos, DIRECTED_ROWS[i].col, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].status, DIRECTED_ROWS[i].card_byte);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      // drain before touching the registers
      s_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      write_reg(REG_TRUNCATE_LONG, {31'd0, phase % 2 == 0});
      write_reg(REG_EOF_EXCEPTION, {31'd0, phase < 2 || phase == 4});
      write_reg(REG_FILL_BYTE, (phase == 0) ? 32'h00 :
                               (phase == 1) ? 32'hFF : 32'($urandom_range(0, 255)));
      calm   = (phase == 1);
      target = fed_items + PHASE_ITEMS;
      while (fed_items < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // one record: text with tabs, carriage returns and reads, then an end mark
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(72, 90) : $urandom_range(0, 24);
          for (n = 0; n < len; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
              send_item(1'b0, CH_CR, 8'($urandom), 1'b0, 7'($urandom));
            end else if (pick < 12) begin
              send_item(1'b0, CH_TAB, 8'($urandom), 1'b0, 7'($urandom));
            end else if (pick < 27) begin
              send_item(1'b1, 8'($urandom), 8'($urandom), 1'($urandom), 7'($urandom));
            end else begin
              send_item(1'b0, 8'($urandom_range(32, 126)), 8'($urandom), 1'b0, 7'($urandom));
            end
          end
          pick = $urandom_range(0, 99);
          if (pick < 80) send_item(1'b0, CH_LF, 8'($urandom), 1'b0, 7'($urandom));
          else if (pick < 90) send_item(1'b0, CH_EOF, 8'($urandom), 1'b0, 7'($urandom));
          else send_item(1'b0, 8'($urandom), 8'($urandom), 1'b1, 7'($urandom));
        end else if (pick < 85) begin
          len = $urandom_range(1, 4);
          for (n = 0; n < len; n++) begin
            rd_col = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, CARD_COLUMNS - 1)) :
                                                    7'($urandom_range(CARD_COLUMNS, 127));
            send_item(1'b1, 8'($urandom), 8'($urandom), 1'($urandom), rd_col);
          end
        end else begin
          send_item(1'($urandom), 8'($urandom), 8'($urandom),
                    $urandom_range(0, 7) == 0, 7'($urandom));
        end
      end
    end

    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
